@@ rtl/core/assert_macros.svh @@
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Implication whose consequent is checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

@@ rtl/core/rgbhsl_pkg.sv @@
`default_nettype none
package rgbhsl_pkg;

  localparam int unsigned NumCells   = 17;
  localparam int unsigned HueSixth   = 3840;
  localparam int unsigned HueFull    = 23040;
  localparam int unsigned FracOne    = 65535;

  // One divider cell's working set, handed to the next cell each cycle that the pipeline advances.
  typedef struct packed {
    logic        vld;
    logic [24:0] rem_hue;   // partial remainder, hue division (2*num)
    logic [24:0] rem_sat;   // partial remainder, saturation division
    logic [9:0]  den_hue;   // 2*delta
    logic [9:0]  den_sat;   // 2*den
    logic [14:0] q_hue;
    logic [16:0] q_sat;
    logic [15:0] light;
    logic        gray;
  } div_beat_t;

endpackage
`default_nettype wire

@@ rtl/core/rgbhsl_front.sv @@
`default_nettype none
// Min/max, sector numerators and lightness for one pixel, registered.
module rgbhsl_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic                   vld_in,
  input  wire logic [7:0]             red,
  input  wire logic [7:0]             green,
  input  wire logic [7:0]             blue,
  output rgbhsl_pkg::div_beat_t       beat_out
);
  import rgbhsl_pkg::*;

  logic [7:0]  mx, mn, delta;
  logic [8:0]  sum, den;
  logic [23:0] num;
  logic [24:0] num2_sat;
  div_beat_t   beat_nxt, beat_r;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    sum   = {1'b0, mx} + {1'b0, mn};
    den   = (sum < 9'd255) ? sum : (9'd510 - sum);
    // Sector numerator times 1/delta units; values fit in 24 bits
    if (red == mx) begin
      if (green >= blue) num = 24'(HueSixth) * 24'(green - blue);
      else num = 24'(HueFull) * 24'(delta) - 24'(HueSixth) * 24'(blue - green);
    end else if (green == mx) begin
      num = 24'(2 * HueSixth) * 24'(delta) + 24'(HueSixth) * 24'(blue)
          - 24'(HueSixth) * 24'(red);
    end else begin
      num = 24'(4 * HueSixth) * 24'(delta) + 24'(HueSixth) * 24'(red)
          - 24'(HueSixth) * 24'(green);
    end
    num2_sat = 25'(delta) * 25'(2 * FracOne);
    beat_nxt.vld     = vld_in;
    beat_nxt.gray    = (delta == 8'd0);
    // Rounding: (2n + d) / (2d)
    beat_nxt.rem_hue = {num, 1'b0} + 25'(delta);
    beat_nxt.rem_sat = num2_sat + 25'(den);
    beat_nxt.den_hue = (delta == 8'd0) ? 10'd2 : {1'b0, delta, 1'b0};
    beat_nxt.den_sat = (delta == 8'd0) ? 10'd2 : {den, 1'b0};
    beat_nxt.q_hue   = '0;
    beat_nxt.q_sat   = '0;
    beat_nxt.light   = 16'((18'(sum) * 18'd257 + 18'd1) >> 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r.vld <= beat_nxt.vld;
    end
    if (en) begin
      beat_r.rem_hue <= beat_nxt.rem_hue;
      beat_r.rem_sat <= beat_nxt.rem_sat;
      beat_r.den_hue <= beat_nxt.den_hue;
      beat_r.den_sat <= beat_nxt.den_sat;
      beat_r.q_hue   <= beat_nxt.q_hue;
      beat_r.q_sat   <= beat_nxt.q_sat;
      beat_r.light   <= beat_nxt.light;
      beat_r.gray    <= beat_nxt.gray;
    end
  end

  assign beat_out = beat_r;
endmodule
`default_nettype wire

@@ rtl/core/rgbhsl_cell.sv @@
`default_nettype none
// One restoring-division step at the bit position on bit_pos: saturation always, hue only below bit 15.
module rgbhsl_cell (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   en,
  input  wire logic [4:0]             bit_pos,
  input  wire rgbhsl_pkg::div_beat_t  beat_in,
  output rgbhsl_pkg::div_beat_t       beat_out
);
  import rgbhsl_pkg::*;

  logic [25:0] sh_hue, sh_sat;
  div_beat_t   beat_nxt, beat_r;

  always_comb begin
    beat_nxt = beat_in;
    sh_hue = 26'(beat_in.den_hue) << bit_pos;
    sh_sat = 26'(beat_in.den_sat) << bit_pos;
    // Subtract the shifted divisor where it fits, set the quotient bit
    if (bit_pos < 5'd15 && 26'(beat_in.rem_hue) >= sh_hue) begin
      beat_nxt.rem_hue = beat_in.rem_hue - sh_hue[24:0];
      beat_nxt.q_hue[bit_pos[3:0]] = 1'b1;
    end
    if (26'(beat_in.rem_sat) >= sh_sat) begin
      beat_nxt.rem_sat = beat_in.rem_sat - sh_sat[24:0];
      beat_nxt.q_sat[bit_pos] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r.vld <= 1'b0;
    end else if (en) begin
      beat_r.vld <= beat_nxt.vld;
    end
    if (en) begin
      beat_r.rem_hue <= beat_nxt.rem_hue;
      beat_r.rem_sat <= beat_nxt.rem_sat;
      beat_r.den_hue <= beat_nxt.den_hue;
      beat_r.den_sat <= beat_nxt.den_sat;
      beat_r.q_hue   <= beat_nxt.q_hue;
      beat_r.q_sat   <= beat_nxt.q_sat;
      beat_r.light   <= beat_nxt.light;
      beat_r.gray    <= beat_nxt.gray;
    end
  end

  assign beat_out = beat_r;
endmodule
`default_nettype wire

@@ rtl/core/rgb_to_hsl_converter.sv @@
`default_nettype none
// RGB to HSL pixel converter.
// Input channel: in_valid/in_ready with in_red, in_green, in_blue (8 bits).
// Output channel: out_valid/out_ready with out_hue (1/64 degree, 0..23039),
// out_saturation and out_lightness (fraction times 65535) and out_is_gray.
// Every input beat yields exactly one output beat, in order.
// Throughput: one pixel per clock cycle while the receiver does not stall.
// Pipeline: one front stage (min/max, numerators, lightness) loaded at the
// accepting edge, then a chain of 17 restoring-division cells, one quotient
// bit each, then the output register.
// Reset (synchronous, active low) empties the whole pipeline.
// When the receiver stalls, the pipeline advances only while the output
// register is empty or being drained; in_ready falls with it, so the
// block stalls as a whole and no beat is lost.
module rgb_to_hsl_converter (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [14:0] out_hue,
  output      logic [15:0] out_saturation,
  output      logic [15:0] out_lightness,
  output      logic        out_is_gray
);
  import rgbhsl_pkg::*;

  logic      adv;
  div_beat_t chain [NumCells+1];
  logic        out_valid_r;
  logic [14:0] hue_r, hue_nxt;
  logic [15:0] sat_r, lit_r;
  logic        gray_r;

  // Advance the pipeline when the output slot is free or drains
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  rgbhsl_front u_front (
    .clk, .rst_n, .en(adv), .vld_in(in_valid),
    .red(in_red), .green(in_green), .blue(in_blue), .beat_out(chain[0])
  );

  // Quotient bits from the top down
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rgbhsl_cell u_cell (
      .clk, .rst_n, .en(adv), .bit_pos(5'(NumCells - 1 - i)),
      .beat_in(chain[i]), .beat_out(chain[i+1])
    );
  end

  // Wrap a full turn to zero
  always_comb begin
    hue_nxt = chain[NumCells].q_hue;
    if (hue_nxt == 15'(HueFull)) hue_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= chain[NumCells].vld;
    end
    if (adv) begin
      gray_r <= chain[NumCells].gray;
      lit_r  <= chain[NumCells].light;
      hue_r  <= chain[NumCells].gray ? '0 : hue_nxt;
      sat_r  <= chain[NumCells].gray ? '0 : chain[NumCells].q_sat[15:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_lightness  = lit_r;
  assign out_is_gray    = gray_r;
endmodule
`default_nettype wire

@@ rtl/core/rgbhsl_checker.sv @@
`default_nettype none
`include "assert_macros.svh"
// Port-level checks on the converter.
module rgbhsl_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [14:0] out_hue,
  input wire logic [15:0] out_saturation,
  input wire logic        out_is_gray
);
  logic gray_zero;

  // Gray beats carry zero hue and saturation
  assign gray_zero = (out_hue == 15'd0) && (out_saturation == 16'd0);

  `CHK_IMPLY(a_hue_range, clk, rst_n, out_valid, out_hue < 15'd23040)
  `CHK_IMPLY(a_gray_zero, clk, rst_n, out_valid && out_is_gray, gray_zero)
  `CHK_IMPLY(a_ready_free, clk, rst_n, !out_valid, in_ready)
  `CHK_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_hue))
  `CHK_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)
endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_rgbhsl_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_hue, .out_saturation, .out_is_gray
);
`default_nettype wire

@@ tb/tb_rgb_to_hsl_converter.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb_rgb_to_hsl_converter;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct {
    logic [14:0] hue;
    logic [15:0] sat;
    logic [15:0] light;
    logic        gray;
  } hsl_t;

  localparam int unsigned HueSixthC = 3840;
  localparam int unsigned HueTurnC  = 23040;
  localparam int unsigned FracOneC  = 65535;
  localparam int LimitCycles = 200000;
  localparam int LatencyC    = 19;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_red;
  logic [7:0]  in_green;
  logic [7:0]  in_blue;
  logic        out_valid;
  logic        out_ready;
  logic [14:0] out_hue;
  logic [15:0] out_saturation;
  logic [15:0] out_lightness;
  logic        out_is_gray;

  pixel_t pixel_q[$];
  hsl_t   hsl_q[$];
  int     errors;
  int     cycles;
  int     accepted;
  int     received;
  int     gray_seen;
  bit     stim_done;
  bit     long_hold;
  bit     sender_pause;

  rgb_to_hsl_converter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hue(out_hue), .out_saturation(out_saturation),
    .out_lightness(out_lightness), .out_is_gray(out_is_gray)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Exact rational conversion, rounded to nearest with ties upward.
  function automatic hsl_t convert_pixel(pixel_t p);
    int unsigned r, g, b, mx, mn, dlt, sum, den, num, h;
    hsl_t res;
    r = p.red; g = p.green; b = p.blue;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    dlt = mx - mn;
    sum = mx + mn;
    res.light = 16'((sum * 257 + 1) / 2);
    res.gray = (dlt == 0);
    res.hue = '0;
    res.sat = '0;
    if (dlt != 0) begin
      den = (sum < 255) ? sum : 510 - sum;
      res.sat = 16'((2 * dlt * FracOneC + den) / (2 * den));
      if (r == mx) begin
        if (g >= b) num = HueSixthC * (g - b);
        else num = HueTurnC * dlt - HueSixthC * (b - g);
      end else if (g == mx) begin
        num = 2 * HueSixthC * dlt + HueSixthC * b - HueSixthC * r;
      end else begin
        num = 4 * HueSixthC * dlt + HueSixthC * r - HueSixthC * g;
      end
      h = (2 * num + dlt) / (2 * dlt);
      if (h >= HueTurnC) h -= HueTurnC;
      res.hue = 15'(h);
    end
    return res;
  endfunction

  function automatic pixel_t mk(int r, int g, int b);
    pixel_t p;
    p.red = 8'(r); p.green = 8'(g); p.blue = 8'(b);
    return p;
  endfunction

  // Fill the pixel queue: directed corners, then random mixes.
  initial begin
    int k, m;
    pixel_q.push_back(mk(0, 0, 0));
    pixel_q.push_back(mk(255, 255, 255));
    pixel_q.push_back(mk(128, 128, 128));
    pixel_q.push_back(mk(255, 0, 0));
    pixel_q.push_back(mk(0, 255, 0));
    pixel_q.push_back(mk(0, 0, 255));
    pixel_q.push_back(mk(255, 255, 0));
    pixel_q.push_back(mk(0, 255, 255));
    pixel_q.push_back(mk(255, 0, 255));
    pixel_q.push_back(mk(255, 0, 1));
    pixel_q.push_back(mk(255, 1, 0));
    pixel_q.push_back(mk(1, 0, 0));
    pixel_q.push_back(mk(254, 255, 255));
    pixel_q.push_back(mk(127, 128, 127));
    pixel_q.push_back(mk(127, 127, 128));
    pixel_q.push_back(mk(200, 200, 10));
    pixel_q.push_back(mk(10, 200, 200));
    pixel_q.push_back(mk(200, 10, 200));
    pixel_q.push_back(mk(170, 85, 255));
    pixel_q.push_back(mk(1, 2, 3));
    pixel_q.push_back(mk(85, 170, 0));
    for (k = 0; k < 600; k++) begin
      m = $urandom_range(0, 9);
      if (m == 0) begin
        m = $urandom_range(0, 255);
        pixel_q.push_back(mk(m, m, m));
      end else if (m == 1) begin
        m = $urandom_range(0, 255);
        pixel_q.push_back(mk(m, m, $urandom_range(0, 255)));
      end else if (m == 2) begin
        pixel_q.push_back(mk($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                             $urandom_range(0, 255)));
      end else begin
        pixel_q.push_back(mk($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255)));
      end
    end
  end

  // Drive pixel beats with random gaps; pause once until drained.
  always @(posedge clk) begin
    static int gap = 0;
    pixel_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_red <= '0; in_green <= '0; in_blue <= '0;
    end else begin
      if (in_valid && in_ready) begin
        p.red = in_red; p.green = in_green; p.blue = in_blue;
        hsl_q.push_back(convert_pixel(p));
        accepted++;
        gap = (accepted % 64 < 20) ? 0 : $urandom_range(0, 9);
        if (accepted == 300) sender_pause = 1'b1;
      end
      if (sender_pause && hsl_q.size() == 0 && !(in_valid && in_ready))
        sender_pause = 1'b0;
      if (!in_valid || in_ready) begin
        if (gap == 0 && !sender_pause && pixel_q.size() != 0) begin
          p = pixel_q.pop_front();
          in_valid <= 1'b1;
          in_red <= p.red; in_green <= p.green; in_blue <= p.blue;
        end else begin
          in_valid <= 1'b0;
          if (gap > 0) gap--;
          if (pixel_q.size() == 0 && !sender_pause) stim_done = 1'b1;
        end
      end
    end
  end

  // Check each result beat against the oldest prediction; stall at random.
  always @(posedge clk) begin
    static int stall = 0;
    static int hold_cnt = 0;
    hsl_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        received++;
        if (hsl_q.size() == 0) begin
          $display("%0t: unexpected result hue=%0d", $time, out_hue);
          errors++;
        end else begin
          e = hsl_q.pop_front();
          if (out_is_gray) gray_seen++;
          if (out_hue !== e.hue || out_saturation !== e.sat ||
              out_lightness !== e.light || out_is_gray !== e.gray) begin
            $display("%0t: mismatch exp h=%0d s=%0d l=%0d g=%0b got h=%0d s=%0d l=%0d g=%0b",
                     $time, e.hue, e.sat, e.light, e.gray,
                     out_hue, out_saturation, out_lightness, out_is_gray);
            errors++;
          end
        end
        stall = (received % 50 < 15) ? 0 : $urandom_range(0, 9);
        if (received == 120 && !long_hold) begin
          long_hold = 1'b1;
          hold_cnt = 80;
        end
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Count cycles and stop on a timeout.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    errors = 0; cycles = 0; accepted = 0; received = 0; gray_seen = 0;
    stim_done = 1'b0; long_hold = 1'b0; sender_pause = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0; in_red = '0; in_green = '0; in_blue = '0;
    out_ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && hsl_q.size() == 0);
    repeat (LatencyC * 2) @(posedge clk);
    $display("Converted %0d pixels, %0d results checked, %0d gray.",
             accepted, received, gray_seen);
    $display("Covered primaries, ties, extremes, a long output stall and a drain pause.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
